@@ design/idg_pkg.sv @@
// ----------------------------------------------------------------------------
// idg_pkg: shared types and constants for the implicit diffusion grid step
// Opcodes, register indexes, state types and fixed-point widths.
// ----------------------------------------------------------------------------
package idg_pkg;

  localparam int DefMaxRows = 32;
  localparam int DefMaxCols = 32;

  localparam int DataW  = 32;
  localparam int RatioW = 24;
  localparam int SizeW  = 6;
  localparam int FracW  = 16;

  // divider widths: numerator magnitude of (num << 16), pivot magnitude
  localparam int DivNumW = 58;
  localparam int DivDenW = 41;

  localparam logic [RatioW-1:0] RatioReset = 24'd655360;
  localparam logic [SizeW-1:0]  RowsReset  = 6'd20;
  localparam logic [SizeW-1:0]  ColsReset  = 6'd15;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_RATIO = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_STEP
  } top_state_e;

  typedef enum logic [3:0] {
    SV_IDLE,
    SV_F_RD,
    SV_F_PREP,
    SV_F_DIV,
    SV_B_LAST,
    SV_B_RD,
    SV_B_MUL,
    SV_B_WR,
    SV_DONE
  } solve_state_e;

  typedef struct packed {
    logic done;
    logic ovf;
  } idg_stat_t;

endpackage

@@ design/idg_div.sv @@
// ----------------------------------------------------------------------------
// idg_div: restoring divider, one quotient bit per cycle
// Signed numerator over positive divisor, truncated toward zero and
// saturated to 32 bits with an overflow flag.
// ----------------------------------------------------------------------------
module idg_div #(
  parameter int NumW = idg_pkg::DivNumW,
  parameter int DenW = idg_pkg::DivDenW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NumW-1:0]    num_i,
  input  logic        [DenW-1:0]    den_i,
  output logic                      done_o,
  output logic signed [31:0]        quo_o,
  output logic                      ovf_o
);
  import idg_pkg::*;

  localparam int CntW = $clog2(NumW + 1);
  localparam logic [NumW-1:0] PosLim = {{(NumW-31){1'b0}}, {31{1'b1}}};
  localparam logic [NumW-1:0] NegLim = PosLim + NumW'(1);

  logic            busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d, trial;
  logic [DenW-1:0] den_q, den_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[NumW-1];
      quo_d  = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  always_comb begin
    ovf_o = 1'b0;
    if (neg_q) begin
      if (quo_q > NegLim) begin
        quo_o = 32'sh8000_0000;
        ovf_o = 1'b1;
      end else begin
        quo_o = $signed(32'(-quo_q));
      end
    end else begin
      if (quo_q > PosLim) begin
        quo_o = 32'sh7fff_ffff;
        ovf_o = 1'b1;
      end else begin
        quo_o = $signed(quo_q[31:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

@@ design/idg_solver.sv @@
// ----------------------------------------------------------------------------
// idg_solver: line sequencer and Thomas solve
// Sweeps every column then every row, forward elimination into the sweep
// memory and back substitution into the grid memory.
// ----------------------------------------------------------------------------
module idg_solver #(
  parameter int MaxRows = idg_pkg::DefMaxRows,
  parameter int MaxCols = idg_pkg::DefMaxCols,
  parameter int SweepLen = (MaxRows > MaxCols) ? MaxRows : MaxCols,
  parameter int CntW = $clog2(SweepLen + 1),
  parameter int AddrW = $clog2(MaxRows * MaxCols)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [idg_pkg::RatioW-1:0]     ratio_i,
  input  logic [CntW-1:0]                rows_i,
  input  logic [CntW-1:0]                cols_i,
  output logic                           grid_re_o,
  output logic                           grid_we_o,
  output logic [AddrW-1:0]               grid_addr_o,
  output logic signed [31:0]             grid_wdata_o,
  input  logic signed [31:0]             grid_rdata_i,
  output idg_pkg::idg_stat_t             stat_o
);
  import idg_pkg::*;

  localparam int SwW = $clog2(SweepLen);

  solve_state_e state_q, state_d;

  logic            phase_q, phase_d;
  logic [CntW-1:0] k_q, k_d, i_q, i_d;
  logic signed [31:0] prev_c_q, prev_c_d, prev_d_q, prev_d_d, x_q, x_d;
  logic signed [56:0] prodc_q, prodd_q, prodc_sh, prodd_sh;
  logic signed [63:0] prodx_q, prodx_sh;

  logic [CntW-1:0] n_len, n_lines;
  logic            last, is_end;
  logic [26:0]     b_diag;
  logic signed [41:0] m_full, num_full;
  logic [DivDenW-1:0] den;
  logic signed [DivNumW-1:0] nc, nd;
  logic signed [31:0] qc, qd;
  logic            ovfc, ovfd, div_done, div_done_d, div_start;
  logic signed [31:0] coeff;
  logic signed [48:0] diff;
  logic signed [31:0] x_new;
  logic            x_ovf;

  logic [63:0] sweep_mem [SweepLen];
  logic [63:0] sweep_rdata_q;
  logic        sweep_we, sweep_re;

  assign n_len   = phase_q ? cols_i : rows_i;
  assign n_lines = phase_q ? rows_i : cols_i;
  assign last    = (i_q == n_len - CntW'(1));
  assign is_end  = (i_q == '0) || last;

  always_comb begin
    if (phase_q) grid_addr_o = AddrW'(32'(k_q) * MaxCols + 32'(i_q));
    else         grid_addr_o = AddrW'(32'(i_q) * MaxCols + 32'(k_q));
  end

  // forward step arithmetic
  assign prodc_sh = prodc_q >>> FracW;
  assign prodd_sh = prodd_q >>> FracW;
  assign b_diag   = 27'(32'h1_0000) + (is_end ? 27'(ratio_i) : 27'({ratio_i, 1'b0}));
  assign m_full   = $signed({15'd0, b_diag}) + $signed(prodc_sh[41:0]);
  assign num_full = $signed({{10{grid_rdata_i[31]}}, grid_rdata_i}) + $signed(prodd_sh[41:0]);
  // pivot guard
  assign den = (m_full < 42'sd1) ? DivDenW'(1) : m_full[DivDenW-1:0];
  assign nc  = -$signed({18'd0, ratio_i, 16'd0});
  assign nd  = $signed({num_full, 16'd0});

  idg_div u_div_c (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (nc),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (qc),
    .ovf_o   (ovfc)
  );

  idg_div u_div_d (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (nd),
    .den_i   (den),
    .done_o  (div_done_d),
    .quo_o   (qd),
    .ovf_o   (ovfd)
  );

  assign coeff = last ? 32'sd0 : qc;

  // back substitution arithmetic
  assign prodx_sh = prodx_q >>> FracW;
  assign diff = $signed({{17{sweep_rdata_q[31]}}, sweep_rdata_q[31:0]})
              - $signed(prodx_sh[48:0]);
  always_comb begin
    x_ovf = 1'b0;
    if (diff > 49'sh0_7fff_ffff) begin
      x_new = 32'sh7fff_ffff;
      x_ovf = 1'b1;
    end else if (diff < -49'sh0_8000_0000) begin
      x_new = 32'sh8000_0000;
      x_ovf = 1'b1;
    end else begin
      x_new = $signed(diff[31:0]);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SV_IDLE:   if (start_i) state_d = SV_F_RD;
      SV_F_RD:   state_d = SV_F_PREP;
      SV_F_PREP: state_d = SV_F_DIV;
      SV_F_DIV:  if (div_done && div_done_d) state_d = last ? SV_B_LAST : SV_F_RD;
      SV_B_LAST: state_d = SV_B_RD;
      SV_B_RD:   state_d = SV_B_MUL;
      SV_B_MUL:  state_d = SV_B_WR;
      SV_B_WR: begin
        if (i_q != '0)                state_d = SV_B_RD;
        else if (k_q != n_lines - CntW'(1)) state_d = SV_F_RD;
        else if (!phase_q)            state_d = SV_F_RD;
        else                          state_d = SV_DONE;
      end
      SV_DONE:   state_d = SV_IDLE;
      default:   state_d = SV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    grid_re_o    = 1'b0;
    grid_we_o    = 1'b0;
    grid_wdata_o = x_new;
    div_start    = 1'b0;
    sweep_we     = 1'b0;
    sweep_re     = 1'b0;
    stat_o       = '0;
    unique case (state_q)
      SV_F_RD:   grid_re_o = 1'b1;
      SV_F_PREP: div_start = 1'b1;
      SV_F_DIV: begin
        sweep_we   = div_done && div_done_d;
        stat_o.ovf = div_done && div_done_d && ((!last && ovfc) || ovfd);
      end
      SV_B_LAST: begin
        grid_we_o    = 1'b1;
        grid_wdata_o = prev_d_q;
      end
      SV_B_RD:   sweep_re = 1'b1;
      SV_B_WR: begin
        grid_we_o  = 1'b1;
        stat_o.ovf = x_ovf;
      end
      SV_DONE:   stat_o.done = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    phase_d  = phase_q;
    k_d      = k_q;
    i_d      = i_q;
    prev_c_d = prev_c_q;
    prev_d_d = prev_d_q;
    x_d      = x_q;
    unique case (state_q)
      SV_IDLE: begin
        phase_d  = 1'b0;
        k_d      = '0;
        i_d      = '0;
        prev_c_d = '0;
        prev_d_d = '0;
      end
      SV_F_DIV: begin
        if (div_done && div_done_d) begin
          prev_c_d = coeff;
          prev_d_d = qd;
          if (!last) i_d = i_q + CntW'(1);
        end
      end
      SV_B_LAST: begin
        x_d = prev_d_q;
        i_d = i_q - CntW'(1);
      end
      SV_B_WR: begin
        x_d = x_new;
        if (i_q != '0) begin
          i_d = i_q - CntW'(1);
        end else begin
          prev_c_d = '0;
          prev_d_d = '0;
          if (k_q != n_lines - CntW'(1)) begin
            k_d = k_q + CntW'(1);
          end else begin
            k_d     = '0;
            phase_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_IDLE;
      phase_q <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_c_q <= prev_c_d;
    prev_d_q <= prev_d_d;
    x_q      <= x_d;
    prodc_q  <= $signed({1'b0, ratio_i}) * prev_c_q;
    prodd_q  <= $signed({1'b0, ratio_i}) * prev_d_q;
    prodx_q  <= $signed(sweep_rdata_q[63:32]) * x_q;
  end

  // sweep scratch: {coeff, rhs}
  always_ff @(posedge clk_i) begin
    if (sweep_we) sweep_mem[i_q[SwW-1:0]] <= {coeff, qd};
    if (sweep_re) sweep_rdata_q <= sweep_mem[i_q[SwW-1:0]];
  end

endmodule

@@ design/implicit_diffusion_grid_step.sv @@
// ----------------------------------------------------------------------------
// implicit_diffusion_grid_step: backward-Euler 2D diffusion on a stored grid
// Grid memory, item decode, configuration and result register.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser carries the opcode, tdata row, column, value.
// Write cell: result beat loaded on the accept edge.
// Read cell: the synchronous grid memory read is registered, then T_READ loads the result beat.
// Unused opcode: read_value 0, result beat loaded on the accept edge.
// Step: every active column, then every row, is solved in turn. Each cell
//   of a line passes the bit-serial divider (NumW = 58) in the forward
//   sweep and is then written back by back substitution; the divider
//   dominates the time a step takes.
// Every item gives exactly one result beat on m_axis carrying read_value
//   and the sticky overflow flag.
// A new item is taken only while the block is idle and its result slot is
//   free or being drained; a stalled receiver holds the block off.
// Reset clears the flag and loads the default ratio and grid size; grid
//   contents are undefined until written. Configuration writes on the cfg
//   port take effect at once and are meant for an idle block.
// ----------------------------------------------------------------------------
module implicit_diffusion_grid_step #(
  parameter int MaxRows = idg_pkg::DefMaxRows,
  parameter int MaxCols = idg_pkg::DefMaxCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row_index[4:0], col_index[9:5], cell_value[41:10]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // read_value[31:0]
  output logic        m_axis_tuser,  // overflow[0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [idg_pkg::RatioW-1:0] cfg_data_i
);
  import idg_pkg::*;

  localparam int SweepLen = (MaxRows > MaxCols) ? MaxRows : MaxCols;
  localparam int CntW     = $clog2(SweepLen + 1);
  localparam int Depth    = MaxRows * MaxCols;
  localparam int AddrW    = $clog2(Depth);

  top_state_e state_q, state_d;

  logic [RatioW-1:0] ratio_q;
  logic [SizeW-1:0]  rows_q, cols_q;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d, out_ovf_q, out_ovf_d;
  logic [31:0]       out_data_q, out_data_d;

  logic        accept, in_store, step_start;
  op_e         op;
  logic [4:0]  row_idx, col_idx;
  logic [31:0] cell_val;
  logic [AddrW-1:0] item_addr;
  logic [CntW-1:0]  rows_c, cols_c;
  idg_stat_t   stat;

  logic              sv_re, sv_we;
  logic [AddrW-1:0]  sv_addr;
  logic signed [31:0] sv_wdata;
  logic              mem_re, mem_we;
  logic [AddrW-1:0]  mem_addr;
  logic [31:0]       mem_wdata, mem_rdata_q;
  logic [31:0]       grid_mem [Depth];

  assign op       = op_e'(s_axis_tuser);
  assign row_idx  = s_axis_tdata[4:0];
  assign col_idx  = s_axis_tdata[9:5];
  assign cell_val = s_axis_tdata[41:10];
  assign in_store = (32'(row_idx) < MaxRows) && (32'(col_idx) < MaxCols);
  assign item_addr = AddrW'(32'(row_idx) * MaxCols + 32'(col_idx));

  assign s_axis_tready = (state_q == T_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step_start    = accept && (op == OP_STEP);

  always_comb begin
    if (9'(rows_q) < 9'd2)            rows_c = CntW'(2);
    else if (32'(rows_q) > MaxRows)   rows_c = CntW'(MaxRows);
    else                              rows_c = CntW'(rows_q);
    if (9'(cols_q) < 9'd2)            cols_c = CntW'(2);
    else if (32'(cols_q) > MaxCols)   cols_c = CntW'(MaxCols);
    else                              cols_c = CntW'(cols_q);
  end

  idg_solver #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_solver (
    .clk_i, .rst_ni,
    .start_i      (step_start),
    .ratio_i      (ratio_q),
    .rows_i       (rows_c),
    .cols_i       (cols_c),
    .grid_re_o    (sv_re),
    .grid_we_o    (sv_we),
    .grid_addr_o  (sv_addr),
    .grid_wdata_o (sv_wdata),
    .grid_rdata_i ($signed(mem_rdata_q)),
    .stat_o       (stat)
  );

  // grid port: solver owns it during a step
  always_comb begin
    if (state_q == T_STEP) begin
      mem_re    = sv_re;
      mem_we    = sv_we;
      mem_addr  = sv_addr;
      mem_wdata = sv_wdata;
    end else begin
      mem_re    = accept && (op == OP_READ) && in_store;
      mem_we    = accept && (op == OP_WRITE) && in_store;
      mem_addr  = item_addr;
      mem_wdata = cell_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= grid_mem[mem_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept && op == OP_READ)      state_d = T_READ;
        else if (accept && op == OP_STEP) state_d = T_STEP;
      end
      T_READ:  state_d = T_IDLE;
      T_STEP:  if (stat.done) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  // result register and flag
  logic read_hit_q;

  always_comb begin
    ovf_d       = ovf_q | ((state_q == T_STEP) && stat.ovf);
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept && (op == OP_WRITE || op == OP_NOP)) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_ovf_d   = ovf_d;
        end
      end
      T_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = read_hit_q ? mem_rdata_q : '0;
        out_ovf_d   = ovf_d;
      end
      T_STEP: begin
        if (stat.done) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_ovf_d   = ovf_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      ratio_q     <= RatioReset;
      rows_q      <= RowsReset;
      cols_q      <= ColsReset;
    end else begin
      state_q     <= state_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RATIO: ratio_q <= cfg_data_i;
          CFG_ROWS:  rows_q  <= cfg_data_i[SizeW-1:0];
          CFG_COLS:  cols_q  <= cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_ovf_q  <= out_ovf_d;
    if (accept) read_hit_q <= in_store;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule
